// ----- hw/rtl/spmv_pkg.sv -----
package spmv_pkg;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_START   = 2'd1,
        FUNC_NONZERO = 2'd2
    } t_func;

    localparam int VECTOR_DEPTH_DEF = 1024;

    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int PROD_W = 48;
    localparam int SUM_W = 49;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(64'sd2147483648);

    // Control that travels down the pipeline with each transaction
    typedef struct packed {
        logic             valid;
        logic             start;
        logic             last;
        logic [IDX_W-1:0] row;
    } t_ctl;

endpackage

// ----- hw/rtl/spmv_vec_mem.sv -----
module spmv_vec_mem
    import spmv_pkg::*;
#(
    parameter int DEPTH = VECTOR_DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_addr,
    input  logic [VAL_W-1:0] i_wr_data,
    output logic [VAL_W-1:0] o_rd_data
);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    // Write a vector entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_addr] <= i_wr_data;
        end
    end

    // Registered read, hold while stalled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/spmv_mac.sv -----
module spmv_mac
    import spmv_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  t_ctl                    i_ctl,
    input  logic signed [VAL_W-1:0] i_x,
    input  logic signed [VAL_W-1:0] i_operand,
    output logic                    o_valid,
    output logic [IDX_W-1:0]        o_row,
    output logic signed [VAL_W-1:0] o_sum,
    output logic                    o_clip
);

    t_ctl                     r_ctl;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [VAL_W-1:0]  r_init;

    logic signed [VAL_W-1:0]  r_sum;
    logic [IDX_W-1:0]         r_row;
    logic                     r_clip;

    logic                     r_out_valid;
    logic [IDX_W-1:0]         r_out_row;
    logic signed [VAL_W-1:0]  r_out_sum;
    logic                     r_out_clip;

    logic signed [2*VAL_W-1:0] full_prod;
    logic signed [SUM_W-1:0]   wide_sum;
    logic signed [VAL_W-1:0]   n_sum;
    logic [IDX_W-1:0]          n_row;
    logic                      n_clip;

    // Multiply and drop the low fraction bits (floor)
    assign full_prod = (2*VAL_W)'(i_x) * (2*VAL_W)'(i_operand);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl  <= i_ctl;
            r_prod <= full_prod[2*VAL_W-1:16];
            r_init <= i_operand;
        end
    end

    // Accumulate with saturation, or open a new row
    always_comb begin
        wide_sum = SUM_W'(r_sum) + SUM_W'(r_prod);
        n_sum    = r_sum;
        n_row    = r_row;
        n_clip   = r_clip;
        if (r_ctl.start) begin
            n_sum  = r_init;
            n_row  = r_ctl.row;
            n_clip = 1'b0;
        end else if (wide_sum > SUM_MAX) begin
            n_sum  = SUM_MAX[VAL_W-1:0];
            n_clip = 1'b1;
        end else if (wide_sum < SUM_MIN) begin
            n_sum  = SUM_MIN[VAL_W-1:0];
            n_clip = 1'b1;
        end else begin
            n_sum  = wide_sum[VAL_W-1:0];
        end
    end

    // Update row state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_row  <= '0;
            r_clip <= 1'b0;
        end else if (i_en && r_ctl.valid) begin
            r_sum  <= n_sum;
            r_row  <= n_row;
            r_clip <= n_clip;
        end
    end

    // Load the output register when a row closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_ctl.valid && r_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_row  <= n_row;
            r_out_sum  <= n_sum;
            r_out_clip <= n_clip;
        end
    end

    assign o_valid = r_out_valid;
    assign o_row   = r_out_row;
    assign o_sum   = r_out_sum;
    assign o_clip  = r_out_clip;

endmodule

// ----- hw/rtl/csr_sparse_matrix_vector_multiply_unit.sv -----
// Channel  | Direction | Handshake           | Payload
// input    | in        | i_valid / o_stall   | i_func, i_column, i_row, i_operand, i_last_in_row
// result   | out       | o_valid / i_stall   | o_out_row, o_row_sum, o_saturated
//
// One transaction per cycle unless stalled; results pass r_s1, r_ctl and the output register.
// The vector memory is written on accept and read whenever en is high, with one read port.
// Reset clears the pipeline valids and the row state; vector memory stays unwritten.
// A stalled result register freezes the whole pipeline and raises o_stall.
module csr_sparse_matrix_vector_multiply_unit
    import spmv_pkg::*;
#(
    parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF,
    localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1,
    localparam int CW = (AW > IDX_W) ? AW : IDX_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_func,
    input  logic [IDX_W-1:0]        i_column,
    input  logic [IDX_W-1:0]        i_row,
    input  logic signed [VAL_W-1:0] i_operand,
    input  logic                    i_last_in_row,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [IDX_W-1:0]        o_out_row,
    output logic signed [VAL_W-1:0] o_row_sum,
    output logic                    o_saturated
);

    logic                    en;
    logic                    accept;
    logic [CW-1:0]           col_ext;
    logic [AW-1:0]           addr;
    logic                    in_range;
    logic                    is_load;
    logic                    is_start;
    logic                    is_nz;
    logic [VAL_W-1:0]        rd_data;
    logic signed [VAL_W-1:0] x_val;

    t_ctl                    r_s1;
    logic signed [VAL_W-1:0] r_s1_operand;
    logic                    r_s1_in_range;

    // Advance everything unless the result register is held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign accept  = i_valid && en;

    assign is_load  = (i_func == FUNC_LOAD);
    assign is_start = (i_func == FUNC_START);
    assign is_nz    = (i_func == FUNC_NONZERO);

    assign col_ext  = CW'(i_column);
    assign addr     = col_ext[AW-1:0];
    assign in_range = 32'(i_column) < 32'(VECTOR_DEPTH);

    spmv_vec_mem #(
        .DEPTH(VECTOR_DEPTH)
    ) u_vec_mem (
        .i_clk    (i_clk),
        .i_wr_en  (accept && is_load && in_range),
        .i_rd_en  (en),
        .i_addr   (addr),
        .i_wr_data(i_operand),
        .o_rd_data(rd_data)
    );

    // Capture start and nonzero transactions beside the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (en) begin
            r_s1.valid    <= accept && (is_start || is_nz);
            r_s1.start    <= is_start;
            r_s1.last     <= i_last_in_row;
            r_s1.row      <= i_row;
            r_s1_operand  <= i_operand;
            r_s1_in_range <= in_range;
        end
    end

    // Out-of-range columns read zero
    assign x_val = r_s1_in_range ? rd_data : '0;

    spmv_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (r_s1),
        .i_x      (x_val),
        .i_operand(r_s1_operand),
        .o_valid  (o_valid),
        .o_row    (o_out_row),
        .o_sum    (o_row_sum),
        .o_clip   (o_saturated)
    );

endmodule
